### hw/rtl/nls_pkg.sv
package nls_pkg;

	localparam int unsigned XW = 32;

	typedef enum logic [1:0] {
		ACT_LN    = 2'd0,
		ACT_LOG2  = 2'd1,
		ACT_LOG10 = 2'd2,
		ACT_BASE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_ARG = 2'd1,
		ST_BAD_BASE = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

	localparam logic [63:0] LN2_Q30  = 64'd744261118;
	localparam logic [63:0] LN10_Q30 = 64'd2472381918;
	localparam logic [63:0] Q30_ONE  = 64'd1 << 30;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RED_HI,
		S_RED_LO,
		S_WDIV,
		S_TERM,
		S_MUL,
		S_LNDONE,
		S_FDIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

### hw/rtl/nls_stream_if.sv
interface nls_stream_if #(
	parameter int unsigned W = 32
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/nls_divider.sv
module nls_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  nls_pkg::div_req_t req,
	output nls_pkg::div_rsp_t rsp
);

	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] trial;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### hw/rtl/natural_log_series_unit.sv
// Logarithm unit: natural log, log2, log10 or log to a given base of an unsigned
// fixed-point argument, one item at a time. An item evaluates one logarithm for ln x,
// or two when a base is given, then a final division, before the result beat. The
// time is set by the shift loop of range reduction (one step a cycle), the bit-serial
// divider shared by w=(m-1)/(m+1) and the final quotient, and one Horner step per
// cycle for each of the TERMS series terms. ready is high only while the unit is idle
// and no result is held; a zero argument returns at once with status 1.
module natural_log_series_unit #(
	parameter int unsigned TERMS     = 64,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	nls_stream_if.sink   in_ch,
	nls_stream_if.source out_ch
);

	localparam int unsigned NW = $clog2(TERMS + 1);
	localparam logic [63:0] ONE_W = 64'd1 << (FRAC_BITS + 32);
	localparam logic [63:0] THR_W = ONE_W << 3;
	localparam logic [63:0] Q30_ONE_L = nls_pkg::Q30_ONE;

	nls_pkg::state_t state_q, state_d;

	logic [1:0]  act_q;
	logic [31:0] base_q;
	logic        second_q;
	logic [63:0] wide_q, acc_q;
	logic [31:0] w_q;
	// k_q carries k*ln2 in Q.30, stepped by ln2 during range reduction
	logic signed [63:0] k_q, num_q, den_q;
	logic [NW-1:0] n_q;
	logic [31:0] res_q;
	logic [1:0]  stat_q;
	logic        neg_q;

	nls_pkg::div_req_t dreq;
	nls_pkg::div_rsp_t drsp;

	nls_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [63:0] m_v, recip_v, prod_lo;
	logic [33:0] mac_v;
	logic [65:0] prod;
	logic signed [63:0] ln_v, den_sel;
	logic [63:0] nm_v, dmag_v;
	logic [63:0] q_sat;
	logic [63:0] lim_v;

	assign m_v = wide_q >> (FRAC_BITS + 2);
	// odd reciprocal, constant divisor per term picked from a small range
	always_comb begin
		recip_v = '0;
		for (int i = 1; i <= TERMS; i += 2)
			if (n_q == NW'(i))
				recip_v = (Q30_ONE_L + 64'(i / 2)) / 64'(i);
	end

	// partial sums stay below 2^32, so a 34 by 32 product is enough
	assign mac_v   = acc_q[33:0] + (n_q[0] ? recip_v[33:0] : 34'd0);
	assign prod    = 66'(mac_v) * 66'(w_q);
	assign prod_lo = 64'(prod[65:30]);
	assign ln_v    = $signed(acc_q << 1) + k_q;

	always_comb begin
		case (act_q)
			nls_pkg::ACT_LN:   den_sel = $signed(Q30_ONE_L);
			nls_pkg::ACT_LOG2: den_sel = $signed(nls_pkg::LN2_Q30);
			nls_pkg::ACT_LOG10: den_sel = $signed(nls_pkg::LN10_Q30);
			default:           den_sel = den_q;
		endcase
	end
	assign nm_v   = num_q[63] ? 64'(-num_q) : 64'(num_q);
	assign dmag_v = den_sel[63] ? 64'(-den_sel) : 64'(den_sel);
	assign lim_v  = neg_q ? 64'h8000_0000 : 64'h7FFF_FFFF;
	assign q_sat  = (drsp.quo > lim_v) ? lim_v : drsp.quo;

	always_comb begin
		state_d   = state_q;
		dreq.start = 1'b0;
		dreq.num  = '0;
		dreq.den  = '0;
		case (state_q)
			nls_pkg::S_IDLE: ;
			nls_pkg::S_RED_HI: if (!(wide_q > THR_W)) state_d = nls_pkg::S_RED_LO;
			nls_pkg::S_RED_LO: if (!(wide_q < ONE_W)) begin
				state_d    = nls_pkg::S_WDIV;
				dreq.start = 1'b1;
				dreq.num   = (m_v - Q30_ONE_L) << 30;
				dreq.den   = m_v + Q30_ONE_L;
			end
			nls_pkg::S_WDIV: if (drsp.done) state_d = nls_pkg::S_TERM;
			nls_pkg::S_TERM: state_d = (n_q == '0) ? nls_pkg::S_LNDONE : nls_pkg::S_TERM;
			nls_pkg::S_LNDONE: ;
			nls_pkg::S_FDIV: if (drsp.done) state_d = nls_pkg::S_OUT;
			nls_pkg::S_OUT: if (out_ch.ready) state_d = nls_pkg::S_IDLE;
			default: state_d = nls_pkg::S_IDLE;
		endcase
		if (state_q == nls_pkg::S_LNDONE) begin
			if (act_q == nls_pkg::ACT_BASE && !second_q) begin
				state_d = (base_q == '0) ? nls_pkg::S_OUT : nls_pkg::S_RED_HI;
			end else if (act_q == nls_pkg::ACT_BASE && ln_v == 0) begin
				state_d = nls_pkg::S_OUT;
			end else begin
				state_d    = nls_pkg::S_FDIV;
				dreq.start = 1'b1;
				dreq.num   = ((second_q ? nm_v : (ln_v[63] ? 64'(-ln_v) : 64'(ln_v)))
				             << FRAC_BITS)
				             + ((act_q == nls_pkg::ACT_BASE ?
				                 (ln_v[63] ? 64'(-ln_v) : 64'(ln_v)) : dmag_v) >> 1);
				dreq.den   = act_q == nls_pkg::ACT_BASE ?
				             (ln_v[63] ? 64'(-ln_v) : 64'(ln_v)) : dmag_v;
			end
		end
		if (state_q == nls_pkg::S_IDLE && in_ch.valid)
			state_d = (in_ch.data[31:0] == '0) ? nls_pkg::S_OUT : nls_pkg::S_RED_HI;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= nls_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nls_pkg::S_IDLE: if (in_ch.valid) begin
				act_q    <= in_ch.data[65:64];
				base_q   <= in_ch.data[63:32];
				wide_q   <= {in_ch.data[31:0], 32'd0};
				k_q      <= '0;
				second_q <= 1'b0;
				res_q    <= '0;
				stat_q   <= (in_ch.data[31:0] == '0) ? nls_pkg::ST_BAD_ARG : nls_pkg::ST_OK;
			end
			nls_pkg::S_RED_HI: if (wide_q > THR_W) begin
				wide_q <= wide_q >> 1;
				k_q    <= k_q + $signed(nls_pkg::LN2_Q30);
			end
			nls_pkg::S_RED_LO: if (wide_q < ONE_W) begin
				wide_q <= wide_q << 1;
				k_q    <= k_q - $signed(nls_pkg::LN2_Q30);
			end
			nls_pkg::S_WDIV: if (drsp.done) begin
				w_q   <= drsp.quo[31:0];
				acc_q <= '0;
				n_q   <= NW'(TERMS);
			end
			nls_pkg::S_TERM: if (n_q != '0) begin
				acc_q <= prod_lo;
				n_q   <= n_q - NW'(1);
			end
			nls_pkg::S_LNDONE: begin
				if (act_q == nls_pkg::ACT_BASE && !second_q) begin
					num_q    <= ln_v;
					second_q <= 1'b1;
					wide_q   <= {base_q, 32'd0};
					k_q      <= '0;
					if (base_q == '0) stat_q <= nls_pkg::ST_BAD_BASE;
				end else if (act_q == nls_pkg::ACT_BASE) begin
					den_q <= ln_v;
					neg_q <= num_q[63] != ln_v[63];
					if (ln_v == 0) stat_q <= nls_pkg::ST_BAD_BASE;
				end else begin
					num_q <= ln_v;
					neg_q <= ln_v[63] != den_sel[63];
				end
			end
			nls_pkg::S_FDIV: if (drsp.done) begin
				res_q  <= neg_q ? 32'(-q_sat) : q_sat[31:0];
				stat_q <= (drsp.quo > lim_v) ? nls_pkg::ST_SAT : nls_pkg::ST_OK;
			end
			default: ;
		endcase
	end

	assign in_ch.ready  = state_q == nls_pkg::S_IDLE;
	assign out_ch.valid = state_q == nls_pkg::S_OUT;
	assign out_ch.data  = {stat_q, res_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("ready while result held");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
		else $error("result changed while stalled");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.data[33:32] == nls_pkg::ST_BAD_ARG ||
		out_ch.data[33:32] == nls_pkg::ST_BAD_BASE) |-> out_ch.data[31:0] == '0)
		else $error("nonzero result on error");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy) else $error("divider restarted while busy");

endmodule

### tb/sv/natural_log_series_unit_tb.sv
module natural_log_series_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IN_W = 2 + 2 * nls_pkg::XW;
	localparam int unsigned OUT_W = nls_pkg::XW + 2;
	localparam int unsigned STALL_LIMIT = 40000;

	typedef struct {
		nls_pkg::action_t act;
		logic [31:0]      x;
		logic [31:0]      b;
		bit               typed;
		logic [31:0]      log_exp;
		nls_pkg::status_t st_exp;
	} log_req_t;

	typedef struct {
		logic [31:0]      log_val;
		nls_pkg::status_t st;
	} log_res_t;

	logic clk;
	logic arst_n;

	nls_stream_if #(.W(IN_W)) in_ch ();
	nls_stream_if #(.W(OUT_W)) out_ch ();

	natural_log_series_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	log_req_t offered_q[$];
	log_res_t expected_logs[$];
	int       fail_count;
	int       beats_in;
	int       beats_out;
	int       sat_seen;
	int       err_seen;
	int       idle_pct;
	int       stall_pct;
	bit       hold_req;
	bit       holding;
	int       quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ln of a nonzero Q16.16 argument, signed Q.30
	function automatic longint ln_q30(input logic [31:0] arg);
		longint unsigned wide, one, m, w, acc;
		longint k;
		int n;
		wide = longint'(arg) << 32;
		one = 64'd1 << (16 + 32);
		acc = 0;
		k = 0;
		while (wide > 8 * one) begin
			wide >>= 1;
			k++;
		end
		while (wide < one) begin
			wide <<= 1;
			k--;
		end
		m = wide >> 18;
		w = ((m - nls_pkg::Q30_ONE) << 30) / (m + nls_pkg::Q30_ONE);
		for (n = 64; n > 0; n--) begin
			if (n % 2 == 1)
				acc += (nls_pkg::Q30_ONE + longint'(n) / 2) / longint'(n);
			acc = (acc * w) >> 30;
		end
		return longint'(2 * acc) + k * longint'(nls_pkg::LN2_Q30);
	endfunction

	function automatic log_res_t predict_log(input log_req_t r);
		log_res_t res;
		longint num, den;
		longint unsigned nm, dm, q, lim;
		bit neg;
		res.log_val = '0;
		res.st = nls_pkg::ST_OK;
		if (r.x == 0) begin
			res.st = nls_pkg::ST_BAD_ARG;
			return res;
		end
		num = ln_q30(r.x);
		case (r.act)
			nls_pkg::ACT_LN:    den = longint'(nls_pkg::Q30_ONE);
			nls_pkg::ACT_LOG2:  den = longint'(nls_pkg::LN2_Q30);
			nls_pkg::ACT_LOG10: den = longint'(nls_pkg::LN10_Q30);
			default: begin
				if (r.b == 0) begin
					res.st = nls_pkg::ST_BAD_BASE;
					return res;
				end
				den = ln_q30(r.b);
				if (den == 0) begin
					res.st = nls_pkg::ST_BAD_BASE;
					return res;
				end
			end
		endcase
		neg = (num < 0) != (den < 0);
		nm = num < 0 ? -num : num;
		dm = den < 0 ? -den : den;
		q = ((nm << 16) + dm / 2) / dm;
		if (q == 0)
			neg = 1'b0;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (q > lim) begin
			q = lim;
			res.st = nls_pkg::ST_SAT;
		end
		res.log_val = neg ? 32'(-q) : 32'(q);
		return res;
	endfunction

	// input side: expectation formed on the accepted beat
	always @(posedge clk) begin
		log_req_t r;
		log_res_t e;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			r = offered_q.pop_front();
			if (r.typed) begin
				e.log_val = r.log_exp;
				e.st = r.st_exp;
			end else begin
				e = predict_log(r);
			end
			expected_logs.push_back(e);
			beats_in++;
		end
	end

	// output side: receiver stalls and result checking
	always @(posedge clk) begin
		log_res_t e;
		nls_pkg::status_t st;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				beats_out++;
				st = nls_pkg::status_t'(out_ch.data[33:32]);
				if (st == nls_pkg::ST_SAT)
					sat_seen++;
				if (st == nls_pkg::ST_BAD_ARG || st == nls_pkg::ST_BAD_BASE)
					err_seen++;
				if (expected_logs.size() == 0) begin
					$error("result beat with nothing expected: log_result %h status %0d",
						out_ch.data[31:0], st);
					fail_count++;
				end else begin
					e = expected_logs.pop_front();
					if (out_ch.data[31:0] !== e.log_val) begin
						$error("log_result: expected %h, got %h", e.log_val,
							out_ch.data[31:0]);
						fail_count++;
					end
					if (out_ch.data[33:32] !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, out_ch.data[33:32]);
						fail_count++;
					end
				end
			end
			out_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off, counted here
	initial begin
		holding = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				holding <= 1'b1;
				repeat (1500) @(posedge clk);
				holding <= 1'b0;
				wait (!hold_req);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: %0d beats pending", expected_logs.size());
			$display("natural_log_series_unit regression: fail");
			$finish;
		end
	end

	task automatic offer_log(input log_req_t r);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		offered_q.push_back(r);
		in_ch.valid <= 1'b1;
		in_ch.data <= {r.act, r.b, r.x};
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom() >> $urandom_range(31);
			2: return 32'h0001_0000 + $urandom_range(64) - 32;
			3: return 32'd1 << $urandom_range(31);
			4: return $urandom_range(3);
			default: return $urandom() | 32'h8000_0000;
		endcase
	endfunction

	function automatic log_req_t rand_req();
		log_req_t r;
		r.act = nls_pkg::action_t'($urandom_range(3));
		r.x = ($urandom_range(40) == 0) ? 32'd0 : rand_q16();
		case ($urandom_range(9))
			0: r.b = 32'd0;
			1: r.b = 32'h0001_0000;
			default: r.b = rand_q16();
		endcase
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic log_req_t row(input nls_pkg::action_t act, input logic [31:0] x,
		input logic [31:0] b, input bit typed, input logic [31:0] lv,
		input nls_pkg::status_t st);
		log_req_t r;
		r.act = act;
		r.x = x;
		r.b = b;
		r.typed = typed;
		r.log_exp = lv;
		r.st_exp = st;
		return r;
	endfunction

	task automatic drain();
		in_ch.valid <= 1'b0;
		wait (expected_logs.size() == 0 && offered_q.size() == 0);
	endtask

	log_req_t directed[$];

	initial begin
		int ph;
		fail_count = 0;
		beats_in = 0;
		beats_out = 0;
		sat_seen = 0;
		err_seen = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero argument, every action; argument error wins over a bad base
		directed.push_back(row(nls_pkg::ACT_LN, 32'd0, 32'h0002_0000, 1, 32'd0,
			nls_pkg::ST_BAD_ARG));
		directed.push_back(row(nls_pkg::ACT_LOG2, 32'd0, 32'd0, 1, 32'd0,
			nls_pkg::ST_BAD_ARG));
		directed.push_back(row(nls_pkg::ACT_LOG10, 32'd0, 32'hFFFF_FFFF, 1, 32'd0,
			nls_pkg::ST_BAD_ARG));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'd0, 32'd0, 1, 32'd0,
			nls_pkg::ST_BAD_ARG));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'd0, 32'h0001_0000, 1, 32'd0,
			nls_pkg::ST_BAD_ARG));
		// bad base: zero, and one whose log is exactly zero
		directed.push_back(row(nls_pkg::ACT_BASE, 32'h0002_0000, 32'd0, 1, 32'd0,
			nls_pkg::ST_BAD_BASE));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'hFFFF_FFFF, 32'h0001_0000, 1, 32'd0,
			nls_pkg::ST_BAD_BASE));
		// log of one is zero in the ln, log2 and log10 modes
		directed.push_back(row(nls_pkg::ACT_LN, 32'h0001_0000, 32'd0, 1, 32'd0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LOG2, 32'h0001_0000, 32'd0, 1, 32'd0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LOG10, 32'h0001_0000, 32'd0, 1, 32'd0,
			nls_pkg::ST_OK));
		// argument and base extremes
		directed.push_back(row(nls_pkg::ACT_LN, 32'd1, 32'd0, 0, 0, nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LN, 32'hFFFF_FFFF, 32'd0, 0, 0, nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LOG2, 32'd1, 32'd0, 0, 0, nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LOG2, 32'hFFFF_FFFF, 32'd0, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LOG10, 32'd1, 32'd0, 0, 0, nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LOG10, 32'h0008_0000, 32'd0, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'h0008_0000, 32'h0002_0000, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'hFFFF_FFFF, 32'd1, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'd1, 32'hFFFF_FFFF, 0, 0,
			nls_pkg::ST_OK));
		// base just off one: huge quotient, saturating both ways
		directed.push_back(row(nls_pkg::ACT_BASE, 32'hFFFF_FFFF, 32'h0001_0001, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'd1, 32'h0001_0001, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_BASE, 32'hFFFF_FFFF, 32'h0000_FFFF, 0, 0,
			nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LN, 32'h0001_0001, 32'd0, 0, 0, nls_pkg::ST_OK));
		directed.push_back(row(nls_pkg::ACT_LN, 32'h0000_FFFF, 32'd0, 0, 0, nls_pkg::ST_OK));
		foreach (directed[i])
			offer_log(directed[i]);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 83; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 83; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			if (ph == 2) begin
				// receiver holds off while items keep coming
				hold_req = 1'b1;
				repeat (6) offer_log(rand_req());
				hold_req = 1'b0;
			end
			repeat (290) offer_log(rand_req());
			// sender pauses until everything is back
			drain();
		end

		repeat (800) @(posedge clk);
		$display("covered %0d beats in, %0d results out (%0d saturated, %0d errors)",
			beats_in, beats_out, sat_seen, err_seen);
		$display("over all four modes with sender gaps and receiver stalls");
		if (fail_count == 0 && expected_logs.size() == 0) begin
			$display("natural_log_series_unit regression: pass");
		end else begin
			$display("natural_log_series_unit regression: fail");
		end
		$finish;
	end

endmodule
